/* design/ubds_pkg.sv */
// constants shared by the baud divisor search unit
package ubds_pkg;

    // field widths
    localparam int CLOCK_W = 28;
    localparam int BAUD_W  = 25;
    localparam int OSR_W   = 6;

    // divisor range
    localparam int DIVISOR_BITS = 13;
    localparam int DIV_MAX      = (1 << DIVISOR_BITS) - 1;

    // oversampling ratio sweep
    localparam int OSR_MIN       = 4;
    localparam int OSR_MAX       = 32;
    localparam int BOTH_EDGE_MAX = 7;

    // clock register reset value
    localparam int CLOCK_RESET = 80000000;

    // ratio times baud fits in baud width plus five bits (ratio at most 32)
    localparam int PROD_W = BAUD_W + 5;

    // shared divider width: covers clock plus half product and ratio times baud
    localparam int DIV_W     = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

endpackage

/* design/ubds_in_if.sv */
// request channel carrying the baud rate
interface ubds_in_if;
    logic                          valid;
    logic                          ready;
    logic [ubds_pkg::BAUD_W-1:0]   baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

/* design/ubds_out_if.sv */
// result channel carrying ratio, divisor and both-edge flag
interface ubds_out_if;
    logic                                valid;
    logic                                ready;
    logic [ubds_pkg::OSR_W-1:0]          oversample_ratio;
    logic [ubds_pkg::DIVISOR_BITS-1:0]   divisor;
    logic                                both_edge;

    modport source (output valid, output oversample_ratio, output divisor,
                    output both_edge, input ready);
    modport sink   (input valid, input oversample_ratio, input divisor,
                    input both_edge, output ready);
endinterface

/* design/ubds_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module ubds_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ubds_pkg::DIV_W-1:0]  dividend,
    input  logic [ubds_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [ubds_pkg::DIV_W-1:0]  quotient
);

    logic [ubds_pkg::DIV_W-1:0]     quo_reg;
    logic [ubds_pkg::DIV_W-1:0]     rem_reg;
    logic [ubds_pkg::DIV_W-1:0]     den_reg;
    logic [ubds_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [ubds_pkg::DIV_W:0]       shifted;
    logic [ubds_pkg::DIV_W+1:0]     diff;
    logic                           neg;

    // trial subtraction of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[ubds_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign neg     = diff[ubds_pkg::DIV_W+1];

    // control: bit counter, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ubds_pkg::DIV_CNT_W'(ubds_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ubds_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ubds_pkg::DIV_W-2:0], ~neg};
            rem_reg <= neg ? shifted[ubds_pkg::DIV_W-1:0] : diff[ubds_pkg::DIV_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/uart_baud_divisor_search_unit.sv */
// top level: searches oversampling ratio and divisor for a requested baud rate
// For each requested baud rate the unit tries every oversampling ratio from 4 to 32,
// forms the rounded divisor clock_hz/(ratio*baud) clamped to 1..8191, computes the
// achieved rate clock_hz/(ratio*divisor) and keeps the first ratio with the smallest
// error. A baud rate of 0 is treated as 1. Both divisions run on one shared bit-serial
// divider, one quotient bit per cycle over 30 bits, first the rounded divisor and then
// the achieved rate for each ratio. A finished result waits in an output register while
// the next item is accepted. clock_hz is written through cfg_we/cfg_wdata; the user must
// write it only while the unit is idle, the unit does not enforce this. It resets to 80 MHz.
module uart_baud_divisor_search_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ubds_pkg::CLOCK_W-1:0]  cfg_wdata,
    ubds_in_if.sink                       baud_in,
    ubds_out_if.source                    result_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD1  = 3'd1;
    localparam logic [2:0] ST_WAIT1  = 3'd2;
    localparam logic [2:0] ST_LOAD2  = 3'd3;
    localparam logic [2:0] ST_WAIT2  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam logic [ubds_pkg::DIV_W-1:0] DivMaxW = ubds_pkg::DIV_W'(ubds_pkg::DIV_MAX);

    logic [2:0]                          state_reg;
    logic [ubds_pkg::CLOCK_W-1:0]        clock_reg;
    logic [ubds_pkg::BAUD_W-1:0]         baud_reg;
    logic [ubds_pkg::OSR_W-1:0]          osr_reg;
    logic [ubds_pkg::DIVISOR_BITS-1:0]   sdiv_reg;
    logic [ubds_pkg::DIV_W-1:0]          best_err_reg;
    logic [ubds_pkg::OSR_W-1:0]          best_osr_reg;
    logic [ubds_pkg::DIVISOR_BITS-1:0]   best_div_reg;
    logic                                out_valid_reg;
    logic [ubds_pkg::OSR_W-1:0]          out_osr_reg;
    logic [ubds_pkg::DIVISOR_BITS-1:0]   out_div_reg;
    logic                                out_both_reg;

    logic                                div_start;
    logic [ubds_pkg::DIV_W-1:0]          div_dividend;
    logic [ubds_pkg::DIV_W-1:0]          div_divisor;
    logic                                div_done;
    logic [ubds_pkg::DIV_W-1:0]          div_quotient;

    logic [ubds_pkg::DIV_W-1:0]          prod;
    logic [ubds_pkg::DIV_W-1:0]          osr_div;
    logic [ubds_pkg::DIV_W-1:0]          baud_w;
    logic [ubds_pkg::DIV_W-1:0]          err;
    logic                                take;
    logic                                out_free;

    // shared divider
    ubds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ratio times baud and ratio times divisor
    assign prod    = ubds_pkg::DIV_W'(osr_reg) * ubds_pkg::DIV_W'(baud_reg);
    assign osr_div = ubds_pkg::DIV_W'(osr_reg) * ubds_pkg::DIV_W'(sdiv_reg);
    assign baud_w  = ubds_pkg::DIV_W'(baud_reg);

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = ubds_pkg::DIV_W'(clock_reg);
        div_divisor  = osr_div;
        if (state_reg == ST_LOAD1)
        begin
            div_start    = 1'b1;
            div_dividend = ubds_pkg::DIV_W'(clock_reg) + (prod >> 1);
            div_divisor  = prod;
        end
        else if (state_reg == ST_LOAD2)
        begin
            div_start = 1'b1;
        end
    end

    // absolute error of the achieved rate and best-so-far test
    assign err      = (div_quotient > baud_w) ? (div_quotient - baud_w)
                                              : (baud_w - div_quotient);
    assign take     = (osr_reg == ubds_pkg::OSR_W'(ubds_pkg::OSR_MIN)) || (err < best_err_reg);
    assign out_free = !out_valid_reg || result_out.ready;

    // clock frequency register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= ubds_pkg::CLOCK_W'(ubds_pkg::CLOCK_RESET);
        end
        else if (cfg_we)
        begin
            clock_reg <= cfg_wdata;
        end
    end

    // search sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (baud_in.valid)
                    begin
                        state_reg <= ST_LOAD1;
                    end
                end
                ST_LOAD1:  state_reg <= ST_WAIT1;
                ST_WAIT1:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_LOAD2;
                    end
                end
                ST_LOAD2:  state_reg <= ST_WAIT2;
                ST_WAIT2:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (osr_reg == ubds_pkg::OSR_W'(ubds_pkg::OSR_MAX))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_LOAD1;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // working registers of the search
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && baud_in.valid)
        begin
            baud_reg <= (baud_in.baud_rate == '0) ? ubds_pkg::BAUD_W'(1) : baud_in.baud_rate;
            osr_reg  <= ubds_pkg::OSR_W'(ubds_pkg::OSR_MIN);
        end
        // clamp the rounded divisor to its range
        if (state_reg == ST_WAIT1 && div_done)
        begin
            if (div_quotient == '0)
            begin
                sdiv_reg <= ubds_pkg::DIVISOR_BITS'(1);
            end
            else if (div_quotient > DivMaxW)
            begin
                sdiv_reg <= ubds_pkg::DIVISOR_BITS'(ubds_pkg::DIV_MAX);
            end
            else
            begin
                sdiv_reg <= div_quotient[ubds_pkg::DIVISOR_BITS-1:0];
            end
        end
        if (state_reg == ST_UPDATE)
        begin
            if (take)
            begin
                best_err_reg <= err;
                best_osr_reg <= osr_reg;
                best_div_reg <= sdiv_reg;
            end
            osr_reg <= osr_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            out_osr_reg  <= best_osr_reg;
            out_div_reg  <= best_div_reg;
            out_both_reg <= (best_osr_reg <= ubds_pkg::OSR_W'(ubds_pkg::BOTH_EDGE_MAX));
        end
    end

    assign baud_in.ready               = (state_reg == ST_IDLE);
    assign result_out.valid            = out_valid_reg;
    assign result_out.oversample_ratio = out_osr_reg;
    assign result_out.divisor          = out_div_reg;
    assign result_out.both_edge        = out_both_reg;

endmodule

/* tb/sv/testbench.sv */
// testbench for the uart baud divisor search unit
`timescale 1ns / 100ps

module testbench;

    // one result item: chosen ratio, divisor and both-edge flag
    typedef struct packed {
        logic [ubds_pkg::OSR_W-1:0]        osr;
        logic [ubds_pkg::DIVISOR_BITS-1:0] divisor;
        logic                              both_edge;
    } baud_fit_t;

    localparam int IDLE_LIMIT = 10000;
    localparam bit [ubds_pkg::CLOCK_W-1:0] CLOCK_TOP = '1;
    localparam bit [ubds_pkg::BAUD_W-1:0]  BAUD_TOP  = '1;

    // tracks the clock register and the fits still owed by the unit
    class divisor_scoreboard;
        bit [ubds_pkg::CLOCK_W-1:0] clock_hz;
        baud_fit_t                  fits_due[$];
        int unsigned                mismatches;

        function new();
            clock_hz   = ubds_pkg::CLOCK_W'(ubds_pkg::CLOCK_RESET);
            mismatches = 0;
        endfunction

        function void set_clock(input bit [ubds_pkg::CLOCK_W-1:0] hz);
            clock_hz = hz;
        endfunction

        function int pending();
            return fits_due.size();
        endfunction

        // sweep every ratio and keep the first one with the smallest error
        function baud_fit_t best_fit(input bit [ubds_pkg::BAUD_W-1:0] baud);
            bit [63:0] rate, clk64, prod, dv, actual, err, best_err, best_div;
            int unsigned osr, best_osr;
            baud_fit_t fit;
            clk64    = 64'(clock_hz);
            rate     = (baud == 0) ? 64'd1 : 64'(baud);
            best_err = 0;
            best_div = 1;
            best_osr = ubds_pkg::OSR_MIN;
            for (osr = ubds_pkg::OSR_MIN; osr <= ubds_pkg::OSR_MAX; osr++)
            begin
                prod = 64'(osr) * rate;
                dv   = (clk64 + prod / 2) / prod;
                if (dv == 0)
                    dv = 1;
                if (dv > 64'(ubds_pkg::DIV_MAX))
                    dv = 64'(ubds_pkg::DIV_MAX);
                actual = clk64 / (64'(osr) * dv);
                err    = (actual > rate) ? actual - rate : rate - actual;
                if (osr == ubds_pkg::OSR_MIN || err < best_err)
                begin
                    best_err = err;
                    best_osr = osr;
                    best_div = dv;
                end
            end
            fit.osr       = best_osr[ubds_pkg::OSR_W-1:0];
            fit.divisor   = best_div[ubds_pkg::DIVISOR_BITS-1:0];
            fit.both_edge = (best_osr >= ubds_pkg::OSR_MIN &&
                             best_osr <= ubds_pkg::BOTH_EDGE_MAX);
            return fit;
        endfunction

        function void note_request(input bit [ubds_pkg::BAUD_W-1:0] baud);
            fits_due.push_back(best_fit(baud));
        endfunction

        function void check_result(input baud_fit_t got);
            baud_fit_t want;
            bit        bad;
            if (fits_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ratio %0d divisor %0d both_edge %0b",
                             got.osr, got.divisor, got.both_edge);
                return;
            end
            want = fits_due.pop_front();
            bad  = 1'b0;
            if (got.osr !== want.osr)
                bad = 1'b1;
            if (got.divisor !== want.divisor)
                bad = 1'b1;
            if (got.both_edge !== want.both_edge)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"fit mismatch at %0t: expected ratio %0d divisor %0d ",
                              "both_edge %0b, got ratio %0d divisor %0d both_edge %0b"},
                             $realtime, want.osr, want.divisor, want.both_edge,
                             got.osr, got.divisor, got.both_edge);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [ubds_pkg::CLOCK_W-1:0] cfg_wdata;
    bit   calm = 1'b0;
    int unsigned idle_cycles = 0;

    divisor_scoreboard sb = new();

    ubds_in_if  baud_if ();
    ubds_out_if res_if ();

    uart_baud_divisor_search_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .baud_in    (baud_if),
        .result_out (res_if)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // offer one baud rate, possibly after a short gap, and hold it until taken
    task automatic send_baud(input bit [ubds_pkg::BAUD_W-1:0] baud);
        int gap;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 6);
            baud_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        baud_if.valid     <= 1'b1;
        baud_if.baud_rate <= baud;
        @(posedge clk);
        while (!baud_if.ready)
            @(posedge clk);
        sb.note_request(baud);
    endtask

    // write the clock register once the unit has delivered everything
    task automatic write_clock(input bit [ubds_pkg::CLOCK_W-1:0] hz);
        baud_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(posedge clk);
        sb.set_clock(hz);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mix of full-range, standard, tiny, ratio-aligned and high baud rates
    function automatic bit [ubds_pkg::BAUD_W-1:0] random_baud(
        input bit [ubds_pkg::CLOCK_W-1:0] hz);
        bit [63:0] pick;
        case ($urandom_range(0, 4))
            0: pick = 64'($urandom());
            1: pick = (($urandom_range(0, 1) ? 64'd115200 : 64'd9600) << 3)
                      >> $urandom_range(0, 7);
            2: pick = 64'($urandom_range(0, 4000));
            3:
            begin
                pick = 64'(hz) / 64'($urandom_range(4, 32) * $urandom_range(1, 64));
                if (pick != 0)
                    pick = pick + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: pick = 64'($urandom_range(100000, 20000000));
        endcase
        return pick[ubds_pkg::BAUD_W-1:0];
    endfunction

    // result side back-pressure in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (res_if.valid && res_if.ready)
                sb.check_result('{res_if.oversample_ratio, res_if.divisor,
                                  res_if.both_edge});
            if ((res_if.valid && res_if.ready) || (baud_if.valid && baud_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int phase;
        bit [ubds_pkg::CLOCK_W-1:0] hz;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        baud_if.valid     <= 1'b0;
        baud_if.baud_rate <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset clock: zero rate, extremes, exact fits, ties, clamped divisor
        send_baud(ubds_pkg::BAUD_W'(0));
        send_baud(ubds_pkg::BAUD_W'(1));
        send_baud(ubds_pkg::BAUD_W'(2));
        send_baud(BAUD_TOP);
        send_baud(ubds_pkg::BAUD_W'(20000000));
        send_baud(ubds_pkg::BAUD_W'(115200));
        send_baud(ubds_pkg::BAUD_W'(9600));
        send_baud(ubds_pkg::BAUD_W'(300));
        send_baud(ubds_pkg::BAUD_W'(625000));
        send_baud(ubds_pkg::BAUD_W'(2500000));
        send_baud(ubds_pkg::BAUD_W'(5000000));
        send_baud(ubds_pkg::BAUD_W'(3000000));

        // zero clock: divisor clamps to one, achieved rate zero
        write_clock(ubds_pkg::CLOCK_W'(0));
        send_baud(ubds_pkg::BAUD_W'(115200));
        send_baud(BAUD_TOP);

        // tiny clock: every ratio ties, lowest kept
        write_clock(ubds_pkg::CLOCK_W'(1));
        send_baud(ubds_pkg::BAUD_W'(1));
        send_baud(ubds_pkg::BAUD_W'(0));

        // widest clock value
        write_clock(CLOCK_TOP);
        send_baud(ubds_pkg::BAUD_W'(1));
        send_baud(BAUD_TOP);
        send_baud(ubds_pkg::BAUD_W'(1000000));

        // random phases over several clock settings, last one without idling
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: hz = ubds_pkg::CLOCK_W'(200000000);
                1: hz = ubds_pkg::CLOCK_W'(1000000);
                2: hz = ubds_pkg::CLOCK_W'(14745600);
                5: hz = ubds_pkg::CLOCK_W'(ubds_pkg::CLOCK_RESET);
                default: hz = ubds_pkg::CLOCK_W'($urandom_range(1000000, 200000000));
            endcase
            write_clock(hz);
            calm = (phase == 5);
            repeat (44) send_baud(random_baud(hz));
        end

        // drain and settle
        baud_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* uart_baud_divisor_search_unit.f */
design/ubds_pkg.sv
design/ubds_in_if.sv
design/ubds_out_if.sv
design/ubds_div.sv
design/uart_baud_divisor_search_unit.sv
tb/sv/testbench.sv
